// ===== rtl/tpr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_pkg: shared definitions for the transport stream PID remapper
// Packet geometry, PID constants, configuration register indexes, the
// per-byte command passed from front end to back end, and the PAT/PMT tables.
// ----------------------------------------------------------------------------
package tpr_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = 8;
    localparam int PID_W        = 13;
    localparam int QUEUE_DEPTH  = 4;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_VIDEO_PID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUDIO_PID = 8'd1;

    localparam logic [CFG_DATA_W-1:0] PID_MASK = 16'h1FFF;
    localparam logic [7:0]            KEEP_MASK = 8'hE0;

    localparam logic [PID_W-1:0] PID_PAT         = 13'd0;
    localparam logic [PID_W-1:0] NEW_VIDEO_PID   = 13'd4001;
    localparam logic [PID_W-1:0] NEW_AUDIO_PID   = 13'd4002;
    localparam logic [PID_W-1:0] RESET_VIDEO_PID = 13'd4001;
    localparam logic [PID_W-1:0] RESET_AUDIO_PID = 13'd4002;

    typedef enum logic [1:0] {
        ACT_PASS = 2'd0,
        ACT_PAT  = 2'd1,
        ACT_PMT  = 2'd2
    } t_action;

    typedef struct packed {
        t_action          action;
        logic [POS_W-1:0] outpos;
        logic [7:0]       data;
    } t_cmd;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    localparam int PAT_LEN   = 37;
    localparam int PMT_LEN   = 50;
    localparam int ROM_IDX_W = $clog2(PMT_LEN);

    localparam logic [7:0] PAT_ROM [PAT_LEN] = '{
        8'h47, 8'h40, 8'h00, 8'h13, 8'h00, 8'h00, 8'hB0, 8'h1D, 8'h00, 8'h20,
        8'hDD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h10, 8'h01, 8'h90, 8'hEF,
        8'hA0, 8'h01, 8'h91, 8'hEF, 8'hAA, 8'h01, 8'h92, 8'hEF, 8'hB4, 8'h01,
        8'h93, 8'hEF, 8'hBE, 8'hE2, 8'hE6, 8'hC1, 8'h15
    };

    localparam logic [7:0] PMT_ROM [PMT_LEN] = '{
        8'h47, 8'h4F, 8'hA0, 8'h15, 8'h00, 8'h02, 8'hB0, 8'h2A, 8'h01, 8'h90,
        8'hC3, 8'h00, 8'h00, 8'hEF, 8'hA1, 8'hF0, 8'h00, 8'h1B, 8'hEF, 8'hA1,
        8'hF0, 8'h00, 8'h11, 8'hEF, 8'hA2, 8'hF0, 8'h07, 8'h1C, 8'h01, 8'h58,
        8'h7C, 8'h02, 8'h58, 8'h00, 8'h11, 8'hEF, 8'hA3, 8'hF0, 8'h07, 8'h1C,
        8'h01, 8'h58, 8'h7C, 8'h02, 8'h58, 8'h00, 8'h90, 8'hB2, 8'h3F, 8'hD6
    };

    // Byte of a replacement packet at a given position; padding is 0xFF.
    function automatic logic [7:0] rom_byte(t_action act, logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'hFF;
        case (act)
            ACT_PAT: begin
                if (pos < POS_W'(PAT_LEN)) begin
                    b = PAT_ROM[pos[ROM_IDX_W-1:0]];
                end
            end
            ACT_PMT: begin
                if (pos < POS_W'(PMT_LEN)) begin
                    b = PMT_ROM[pos[ROM_IDX_W-1:0]];
                end
            end
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/tpr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_front: byte tracking and packet classification
// Holds the configuration registers, packet position and two-byte delay line,
// decides the packet action at header byte 2 and emits one command per byte.
// ----------------------------------------------------------------------------
module tpr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tpr_pkg::t_cfg_wr          i_cfg,
    input  logic                      i_accept,
    input  logic [7:0]                i_in_byte,
    output logic                      o_cmd_push,
    output tpr_pkg::t_cmd             o_cmd
);

    logic [tpr_pkg::PID_W-1:0] r_video_pid, n_video_pid;
    logic [tpr_pkg::PID_W-1:0] r_audio_pid, n_audio_pid;
    logic [tpr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                r_d0, n_d0;
    logic [7:0]                r_d1, n_d1;
    tpr_pkg::t_action          r_action, n_action;
    logic [1:0]                r_fill, n_fill;

    logic [tpr_pkg::PID_W-1:0] pid;
    logic [7:0]                byte_in;
    logic [tpr_pkg::POS_W-1:0] outpos;
    logic                      hdr_pid;

    assign pid     = {r_d0[4:0], i_in_byte};
    assign hdr_pid = (r_pos == tpr_pkg::POS_W'(2));

    always_comb begin
        n_video_pid = r_video_pid;
        n_audio_pid = r_audio_pid;
        if (i_cfg.valid) begin
            if (i_cfg.index == tpr_pkg::REG_VIDEO_PID) begin
                n_video_pid = tpr_pkg::PID_W'(i_cfg.data & tpr_pkg::PID_MASK);
            end else if (i_cfg.index == tpr_pkg::REG_AUDIO_PID) begin
                n_audio_pid = tpr_pkg::PID_W'(i_cfg.data & tpr_pkg::PID_MASK);
            end
        end
    end

    always_comb begin
        n_action = r_action;
        n_d0     = r_d0;
        byte_in  = i_in_byte;
        if (hdr_pid) begin
            n_action = tpr_pkg::ACT_PASS;
            if (pid == tpr_pkg::PID_PAT) begin
                n_action = tpr_pkg::ACT_PAT;
            end else if (r_video_pid != '0 && pid == r_video_pid - 1'b1) begin
                n_action = tpr_pkg::ACT_PMT;
            end else if (pid == r_video_pid) begin
                n_d0    = (r_d0 & tpr_pkg::KEEP_MASK) | {3'b000, tpr_pkg::NEW_VIDEO_PID[12:8]};
                byte_in = tpr_pkg::NEW_VIDEO_PID[7:0];
            end else if (pid == r_audio_pid) begin
                n_d0    = (r_d0 & tpr_pkg::KEEP_MASK) | {3'b000, tpr_pkg::NEW_AUDIO_PID[12:8]};
                byte_in = tpr_pkg::NEW_AUDIO_PID[7:0];
            end
        end

        // The outgoing byte sits two positions behind the incoming one.
        if (r_pos >= tpr_pkg::POS_W'(2)) begin
            outpos = r_pos - tpr_pkg::POS_W'(2);
        end else begin
            outpos = r_pos + tpr_pkg::POS_W'(tpr_pkg::PACKET_BYTES - 2);
        end

        n_d1   = n_d0;
        n_d0   = byte_in;
        n_pos  = (r_pos == tpr_pkg::POS_W'(tpr_pkg::PACKET_BYTES - 1)) ? '0 : r_pos + 1'b1;
        n_fill = (r_fill == 2'd2) ? r_fill : r_fill + 1'b1;
    end

    assign o_cmd_push    = i_accept && (r_fill == 2'd2);
    assign o_cmd.action  = n_action;
    assign o_cmd.outpos  = outpos;
    assign o_cmd.data    = r_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_pid <= tpr_pkg::RESET_VIDEO_PID;
            r_audio_pid <= tpr_pkg::RESET_AUDIO_PID;
            r_pos       <= '0;
            r_d0        <= '0;
            r_d1        <= '0;
            r_action    <= tpr_pkg::ACT_PASS;
            r_fill      <= '0;
        end else begin
            r_video_pid <= n_video_pid;
            r_audio_pid <= n_audio_pid;
            if (i_accept) begin
                r_pos    <= n_pos;
                r_d0     <= n_d0;
                r_d1     <= n_d1;
                r_action <= n_action;
                r_fill   <= n_fill;
            end
        end
    end

endmodule

// ===== rtl/tpr_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_cmd_queue: command queue between front end and back end
// A small register queue; a full queue stops the front end only.
// ----------------------------------------------------------------------------
module tpr_cmd_queue #(
    parameter int DEPTH = tpr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  tpr_pkg::t_cmd i_wr_data,
    output logic          o_full,
    input  logic          i_rd,
    output tpr_pkg::t_cmd o_rd_data,
    output logic          o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tpr_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr, do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/tpr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_back: output byte generation
// Turns a command into the output byte (pass-through or table byte) and holds
// it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module tpr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  tpr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_packet_end
);

    logic       r_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_end, n_end;

    assign o_cmd_pop = i_cmd_valid && (!r_valid || i_pop);

    always_comb begin
        if (i_cmd.action == tpr_pkg::ACT_PASS) begin
            n_byte = i_cmd.data;
        end else begin
            n_byte = tpr_pkg::rom_byte(i_cmd.action, i_cmd.outpos);
        end
        n_end = (i_cmd.outpos == tpr_pkg::POS_W'(tpr_pkg::PACKET_BYTES - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_byte <= n_byte;
            r_end  <= n_end;
        end
    end

    assign o_empty      = !r_valid;
    assign o_out_byte   = r_byte;
    assign o_packet_end = r_end;

endmodule

// ===== rtl/ts_pid_remapper_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pid_remapper_unit: MPEG transport stream PID remapper
// Rewrites the video and audio PIDs of an aligned stream and replaces PAT and
// PMT packets with fixed tables, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input side: drive the next stream byte on i_in_byte and raise push; the
//   transfer happens on a clock edge with push high and full low. The first
//   byte after reset must be the sync byte of a 188-byte packet.
//   Output side: while empty is low, o_out_byte and o_packet_end carry the
//   oldest result; raising pop completes its transfer. o_packet_end marks the
//   last byte of each output packet.
//   Configuration: i_cfg_index 0 selects the video PID, 1 the audio PID; a
//   transfer with i_cfg_valid and o_cfg_ready writes the low 13 bits of
//   i_cfg_data. Other indexes are ignored. Write only while the block is idle.
//   Delay: the stream is delayed by two bytes; the first two input bytes give
//   no output. Each byte passes the command queue and output register. The
//   rate is one byte per cycle in both directions while pop stays high.
//   Reset clears the position, delay line, queue and output register and
//   loads the PID registers with 4001 and 4002. If the receiver stalls, the
//   command queue fills and full rises after QUEUE_DEPTH more bytes.
// ----------------------------------------------------------------------------
module ts_pid_remapper_unit #(
    parameter int QUEUE_DEPTH = tpr_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_in_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_out_byte,
    output logic                           o_packet_end,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tpr_pkg::t_cfg_wr cfg_wr;
    tpr_pkg::t_cmd    push_cmd;
    tpr_pkg::t_cmd    head_cmd;
    logic             cmd_push;
    logic             cmd_pop;
    logic             queue_empty;
    logic             in_accept;

    // Configuration registers are plain flops, so every write is taken at once.
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // A byte is taken whenever the queue has room, independent of the output.
    assign in_accept = push && !full;

    tpr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_wr),
        .i_accept   (in_accept),
        .i_in_byte  (i_in_byte),
        .o_cmd_push (cmd_push),
        .o_cmd      (push_cmd)
    );

    tpr_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (cmd_push),
        .i_wr_data (push_cmd),
        .o_full    (full),
        .i_rd      (cmd_pop),
        .o_rd_data (head_cmd),
        .o_empty   (queue_empty)
    );

    tpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (!queue_empty),
        .i_cmd        (head_cmd),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end)
    );

endmodule

// ===== rtl/tpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_checker: port-level checks for the PID remapper
// Checks held output, packet framing, empty after reset and config readiness.
// ----------------------------------------------------------------------------
module tpr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [7:0]                     o_out_byte,
    input logic                           o_packet_end,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready
);

    logic [tpr_pkg::POS_W-1:0] r_out_pos;
    logic                      out_xfer;

    assign out_xfer = pop && !empty;

    // Position of the next output byte within its packet.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_pos <= '0;
        end else if (out_xfer) begin
            r_out_pos <= (r_out_pos == tpr_pkg::POS_W'(tpr_pkg::PACKET_BYTES - 1)) ?
                         '0 : r_out_pos + 1'b1;
        end
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_packet_end)))
        else $error("result changed while stalled");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result present right after reset");

    a_packet_framing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |->
        (o_packet_end == (r_out_pos == tpr_pkg::POS_W'(tpr_pkg::PACKET_BYTES - 1))))
        else $error("packet end marker out of place");

    a_cfg_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && push && !full) |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind ts_pid_remapper_unit tpr_checker u_tpr_checker (.*);

// ===== sim/ts_pid_remapper_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pid_remapper_checker: scoreboard for the transport stream PID remapper
// Follows every byte and register transfer into the remapper, predicts the
// output stream byte by byte and compares each output transfer with it.
// ----------------------------------------------------------------------------
module ts_pid_remapper_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [7:0]                     i_out_byte,
    input  logic                           i_packet_end,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);

    localparam int          MAX_REPORTS  = 10;
    localparam int          PAT_BYTES    = 37;
    localparam int          PMT_BYTES    = 50;
    localparam logic [12:0] PAT_PID      = 13'd0;
    localparam logic [12:0] VIDEO_TARGET = 13'd4001;
    localparam logic [12:0] AUDIO_TARGET = 13'd4002;
    localparam logic [7:0]  KEEP_BITS    = 8'hE0;
    localparam logic [7:0]  PAD_BYTE     = 8'hFF;

    localparam logic [0:PAT_BYTES-1][7:0] PAT_TABLE = {
        8'h47, 8'h40, 8'h00, 8'h13, 8'h00, 8'h00, 8'hB0, 8'h1D, 8'h00, 8'h20,
        8'hDD, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE0, 8'h10, 8'h01, 8'h90, 8'hEF,
        8'hA0, 8'h01, 8'h91, 8'hEF, 8'hAA, 8'h01, 8'h92, 8'hEF, 8'hB4, 8'h01,
        8'h93, 8'hEF, 8'hBE, 8'hE2, 8'hE6, 8'hC1, 8'h15
    };

    localparam logic [0:PMT_BYTES-1][7:0] PMT_TABLE = {
        8'h47, 8'h4F, 8'hA0, 8'h15, 8'h00, 8'h02, 8'hB0, 8'h2A, 8'h01, 8'h90,
        8'hC3, 8'h00, 8'h00, 8'hEF, 8'hA1, 8'hF0, 8'h00, 8'h1B, 8'hEF, 8'hA1,
        8'hF0, 8'h00, 8'h11, 8'hEF, 8'hA2, 8'hF0, 8'h07, 8'h1C, 8'h01, 8'h58,
        8'h7C, 8'h02, 8'h58, 8'h00, 8'h11, 8'hEF, 8'hA3, 8'hF0, 8'h07, 8'h1C,
        8'h01, 8'h58, 8'h7C, 8'h02, 8'h58, 8'h00, 8'h90, 8'hB2, 8'h3F, 8'hD6
    };

    typedef enum logic [1:0] {
        PKT_PASS = 2'd0,
        PKT_PAT  = 2'd1,
        PKT_PMT  = 2'd2
    } t_pkt_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    logic [12:0]  video_pid_q;
    logic [12:0]  audio_pid_q;
    logic [7:0]   pkt_pos;
    logic [7:0]   recent [2];
    t_pkt_mode    pkt_mode;
    logic [1:0]   warmup;
    t_stream_byte out_q [$];
    int           fails = 0;

    // Advances the model by one input byte and queues the byte it releases.
    task automatic remap_byte(input logic [7:0] in_b);
        logic [7:0]   cur;
        logic [7:0]   pos;
        logic [7:0]   opos;
        logic [12:0]  pid;
        t_stream_byte res;
        cur = in_b;
        pos = (pkt_pos >= 8'(tpr_pkg::PACKET_BYTES)) ? 8'd0 : pkt_pos;
        if (pos == 8'd2) begin
            // The whole packet follows the decision taken on header byte 2.
            pid = {recent[0][4:0], cur};
            pkt_mode = PKT_PASS;
            if (pid == PAT_PID) begin
                pkt_mode = PKT_PAT;
            end else if (video_pid_q != 13'd0 && pid == video_pid_q - 13'd1) begin
                pkt_mode = PKT_PMT;
            end else if (pid == video_pid_q) begin
                recent[0] = (recent[0] & KEEP_BITS) | {3'b000, VIDEO_TARGET[12:8]};
                cur = VIDEO_TARGET[7:0];
            end else if (pid == audio_pid_q) begin
                recent[0] = (recent[0] & KEEP_BITS) | {3'b000, AUDIO_TARGET[12:8]};
                cur = AUDIO_TARGET[7:0];
            end
        end
        opos = (pos >= 8'd2) ? pos - 8'd2 : pos + 8'(tpr_pkg::PACKET_BYTES - 2);
        case (pkt_mode)
            PKT_PAT: res.data = (opos < 8'(PAT_BYTES)) ? PAT_TABLE[opos] : PAD_BYTE;
            PKT_PMT: res.data = (opos < 8'(PMT_BYTES)) ? PMT_TABLE[opos] : PAD_BYTE;
            default: res.data = recent[1];
        endcase
        res.last = (opos == 8'(tpr_pkg::PACKET_BYTES - 1));
        recent[1] = recent[0];
        recent[0] = cur;
        pkt_pos = (pos + 8'd1 >= 8'(tpr_pkg::PACKET_BYTES)) ? 8'd0 : pos + 8'd1;
        if (warmup < 2'd2) begin
            warmup = warmup + 2'd1;
        end else begin
            out_q.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_stream_byte want;
        if (!i_rst_n) begin
            video_pid_q = VIDEO_TARGET;
            audio_pid_q = AUDIO_TARGET;
            pkt_pos = 8'd0;
            recent[0] = 8'd0;
            recent[1] = 8'd0;
            pkt_mode = PKT_PASS;
            warmup = 2'd0;
            out_q.delete();
        end else begin
            // The result side goes first so that a byte accepted at this edge
            // can never be matched by an output that was already waiting.
            if (i_pop && !i_empty) begin
                if (out_q.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("%0t: output transfer with nothing predicted: byte %02h end %0b",
                                 $time, i_out_byte, i_packet_end);
                    end
                end else begin
                    want = out_q.pop_front();
                    if (i_out_byte !== want.data || i_packet_end !== want.last) begin
                        fails++;
                        if (fails <= MAX_REPORTS) begin
                            $display({"%0t: mismatch: expected byte %02h end %0b, ",
                                      "got byte %02h end %0b"},
                                     $time, want.data, want.last, i_out_byte, i_packet_end);
                        end
                    end
                end
            end
            // A byte taken at the same edge as a register write still sees
            // the old register value.
            if (i_push && !i_full) begin
                remap_byte(i_in_byte);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == tpr_pkg::REG_VIDEO_PID) begin
                    video_pid_q = i_cfg_data[12:0];
                end else if (i_cfg_index == tpr_pkg::REG_AUDIO_PID) begin
                    audio_pid_q = i_cfg_data[12:0];
                end
            end
        end
        o_pending    <= out_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/ts_pid_remapper_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pid_remapper_unit_test: stimulus and verdict for the PID remapper
// Feeds an aligned transport stream whose packet headers aim at the remapping
// rules, changes the PID registers between phases and lets the checker compare
// the output stream; both handshakes idle at random in most phases.
// ----------------------------------------------------------------------------
module ts_pid_remapper_unit_test;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [7:0]  SYNC_BYTE    = 8'h47;
    localparam logic [12:0] NULL_PID     = 13'h1FFF;

    // An index that maps to no register; writes to it must change nothing.
    localparam logic [tpr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFE;

    // Which rule the header of the next packet is aimed at.
    typedef enum int {
        KIND_PAT    = 0,
        KIND_PMT    = 1,
        KIND_VIDEO  = 2,
        KIND_AUDIO  = 3,
        KIND_NULL   = 4,
        KIND_NEAR   = 5,
        KIND_RANDOM = 6
    } t_pid_kind;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           push        = 1'b0;
    logic                           full;
    logic [7:0]                     i_in_byte   = 8'd0;
    logic                           empty;
    logic                           pop         = 1'b0;
    logic [7:0]                     o_out_byte;
    logic                           o_packet_end;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [tpr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tpr_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    int pending;
    int fail_count;
    int cycle_count = 0;

    // Gap switches for the two sides; each phase sets them.
    bit idle_in  = 1'b0;
    bit idle_out = 1'b0;

    // Our own view of the PID registers, used only to aim packet headers.
    logic [12:0] video_sel = 13'd4001;
    logic [12:0] audio_sel = 13'd4002;

    // Stream generator state: position in the current packet and its PID.
    int          stream_pos = 0;
    logic [12:0] pkt_pid    = 13'd0;
    t_pid_kind   kind_plan [$];

    ts_pid_remapper_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (o_out_byte),
        .o_packet_end (o_packet_end),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // The checker watches the same wires as the block and reports how many
    // output bytes are still owed and how many checks have failed.
    ts_pid_remapper_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_byte    (i_in_byte),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_byte   (o_out_byte),
        .i_packet_end (o_packet_end),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a correct run finishes far below this many cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Produces the next byte of an endless aligned stream. At each packet
    // start a PID is chosen so that the header hits one of the rules: the
    // PAT PID, the PMT PID one below the video PID, the video or audio PID,
    // the null PID, a near miss or anything at all. The sync byte is mostly
    // right, but the block does not check it, so it is sometimes random.
    task automatic next_stream_byte(output logic [7:0] b);
        t_pid_kind kind;
        if (stream_pos == 0) begin
            if (kind_plan.size() != 0) begin
                kind = kind_plan.pop_front();
            end else begin
                kind = t_pid_kind'($urandom_range(0, 6));
            end
            case (kind)
                KIND_PAT:   pkt_pid = 13'd0;
                KIND_PMT:   pkt_pid = video_sel - 13'd1;
                KIND_VIDEO: pkt_pid = video_sel;
                KIND_AUDIO: pkt_pid = audio_sel;
                KIND_NULL:  pkt_pid = NULL_PID;
                KIND_NEAR:  pkt_pid = audio_sel + 13'd1;
                default:    pkt_pid = 13'($urandom);
            endcase
        end
        case (stream_pos)
            0:       b = ($urandom_range(0, 15) == 0) ? 8'($urandom) : SYNC_BYTE;
            1:       b = {3'($urandom), pkt_pid[12:8]};
            2:       b = pkt_pid[7:0];
            default: b = 8'($urandom);
        endcase
        stream_pos = (stream_pos == tpr_pkg::PACKET_BYTES - 1) ? 0 : stream_pos + 1;
    endtask

    // One input transfer. Push is left high afterwards so that back-to-back
    // bytes never see it dropped and raised within the same time step; the
    // gap loop or the end of the phase lowers it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_in ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
    endtask

    // One register transfer. Valid stays high so that several writes can run
    // back to back; the next phase drops it.
    task automatic write_reg(input logic [tpr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == tpr_pkg::REG_VIDEO_PID) begin
            video_sel = data[12:0];
        end else if (idx == tpr_pkg::REG_AUDIO_PID) begin
            audio_sel = data[12:0];
        end
    endtask

    // A phase streams a number of bytes, which usually ends mid-packet, and
    // then waits until every owed output byte has been taken. The block holds
    // two bytes in its delay line that give no output until more input comes,
    // so after the drain it is idle and registers may be written.
    task automatic run_phase(input int count, input bit gaps_in, input bit gaps_out);
        int         k;
        logic [7:0] b;
        i_cfg_valid <= 1'b0;
        idle_in  = gaps_in;
        idle_out = gaps_out;
        for (k = 0; k < count; k++) begin
            next_stream_byte(b);
            send_byte(b);
        end
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: for every output byte it may hold pop low for a random gap,
    // then keeps pop high until a transfer happens.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_out ? $urandom_range(0, 3) : 0;
            repeat (stall) begin
                pop <= 1'b0;
                @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin
        int ph;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset PIDs, a whole PAT packet goes through and the next
        // packet is aimed at the PMT PID; the phase stops a few bytes into it.
        // The first two input bytes produce nothing.
        kind_plan = '{KIND_PAT, KIND_PMT};
        run_phase(200, 1'b1, 1'b1);

        // The PMT packet is already decided, so moving the video PID to zero
        // in its middle must not change the replacement. The audio write also
        // carries ones above bit 12, which must be dropped.
        write_reg(tpr_pkg::REG_VIDEO_PID, 16'h0000);
        write_reg(tpr_pkg::REG_AUDIO_PID, 16'hFFFF);
        run_phase(60, 1'b0, 1'b0);

        // Overlapping settings: the PMT PID is the PAT PID and audio equals
        // video; the PMT packet still runs on through this phase.
        write_reg(tpr_pkg::REG_VIDEO_PID, 16'h0001);
        write_reg(tpr_pkg::REG_AUDIO_PID, 16'h0001);
        run_phase(60, 1'b0, 1'b1);

        // Top of the range for video, and the audio PID on the PAT PID. The
        // third packet header falls in this phase and is aimed at video.
        write_reg(tpr_pkg::REG_VIDEO_PID, 16'h1FFF);
        write_reg(tpr_pkg::REG_AUDIO_PID, 16'h0000);
        kind_plan = '{KIND_VIDEO};
        run_phase(60, 1'b1, 1'b0);

        // A write to an unmapped index must leave both PIDs alone.
        write_reg(REG_UNMAPPED, 16'($urandom));
        run_phase(30, 1'b1, 1'b1);

        // Random PID settings in the middle of the video packet.
        for (ph = 0; ph < 2; ph++) begin
            write_reg(tpr_pkg::REG_VIDEO_PID, 16'($urandom));
            write_reg(tpr_pkg::REG_AUDIO_PID, 16'($urandom));
            run_phase($urandom_range(15, 25), ph != 1, ph != 0);
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tpr_pkg.sv
rtl/tpr_front.sv
rtl/tpr_cmd_queue.sv
rtl/tpr_back.sv
rtl/ts_pid_remapper_unit.sv
rtl/tpr_checker.sv
sim/ts_pid_remapper_checker.sv
sim/ts_pid_remapper_unit_test.sv
